[hdl/bgtrim_pkg.sv]
// Shared types and codes for the background trim bounding box block.
// Used by the controller, the datapath and the top level.
package bgtrim_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] pix_x;
		logic signed [15:0] pix_y;
		logic [31:0]        pixel_value;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
		logic [31:0]        avoid_color;
	} req_t;

	typedef struct packed {
		logic [7:0] out_left;
		logic [7:0] out_top;
		logic [7:0] out_right;
		logic [7:0] out_bottom;
		logic       all_background;
	} rsp_t;

	// scan position updates
	typedef logic [3:0] pos_op_t;
	localparam pos_op_t POS_HOLD      = 4'd0;
	localparam pos_op_t POS_START_TL  = 4'd1;
	localparam pos_op_t POS_START_BL  = 4'd2;
	localparam pos_op_t POS_START_TR  = 4'd3;
	localparam pos_op_t POS_STEP_X    = 4'd4;
	localparam pos_op_t POS_STEP_Y    = 4'd5;
	localparam pos_op_t POS_ROW_DOWN  = 4'd6;
	localparam pos_op_t POS_ROW_UP    = 4'd7;
	localparam pos_op_t POS_COL_RIGHT = 4'd8;
	localparam pos_op_t POS_COL_LEFT  = 4'd9;

	// rectangle side updates
	typedef logic [2:0] side_op_t;
	localparam side_op_t SIDE_NONE  = 3'd0;
	localparam side_op_t SIDE_T_SET = 3'd1;
	localparam side_op_t SIDE_L_INC = 3'd2;
	localparam side_op_t SIDE_B_DEC = 3'd3;
	localparam side_op_t SIDE_R_DEC = 3'd4;
	localparam side_op_t SIDE_FLAG  = 3'd5;

	typedef struct packed {
		logic     load;
		logic     wr_en;
		pos_op_t  pos;
		side_op_t side;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic inverted;
		logic match;
		logic x_eq_r;
		logic y_eq_b;
		logic xp1_eq_r;
		logic ym1_eq_t;
		logic xm1_eq_l;
		logic l_lt_r;
		logic t_lt_b;
		logic out_full;
	} dp_sts_t;

endpackage

[hdl/bgtrim_chan_if.sv]
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; the block uses bgtrim_pkg::req_t and rsp_t.
interface bgtrim_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/bgtrim_ctrl.sv]
// Controller state machine for the background trim block: sequences the
// four trim phases. Depends on bgtrim_pkg for command and status structs.
module bgtrim_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_cmd,
	output logic                req_ready,
	input  bgtrim_pkg::dp_sts_t sts,
	output bgtrim_pkg::ctl_cmd_t cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_TOP_CHK    = 4'd1;
	localparam logic [3:0] S_TOP_SCAN   = 4'd2;
	localparam logic [3:0] S_LEFT_CHK   = 4'd3;
	localparam logic [3:0] S_LEFT_SCAN  = 4'd4;
	localparam logic [3:0] S_BOT_CHK    = 4'd5;
	localparam logic [3:0] S_BOT_SCAN   = 4'd6;
	localparam logic [3:0] S_RIGHT_CHK  = 4'd7;
	localparam logic [3:0] S_RIGHT_SCAN = 4'd8;
	localparam logic [3:0] S_OUT        = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.wr_en    = 1'b0;
		cmd.pos      = bgtrim_pkg::POS_HOLD;
		cmd.side     = bgtrim_pkg::SIDE_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_cmd == bgtrim_pkg::CMD_QUERY) begin
						cmd.load = 1'b1;
						state_d  = S_TOP_CHK;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			S_TOP_CHK: begin
				if (sts.inverted) begin
					cmd.side = bgtrim_pkg::SIDE_FLAG;
					state_d  = S_OUT;
				end else begin
					cmd.pos = bgtrim_pkg::POS_START_TL;
					state_d = S_TOP_SCAN;
				end
			end
			S_TOP_SCAN: begin
				if (!sts.match) begin
					cmd.side = bgtrim_pkg::SIDE_T_SET;
					state_d  = S_LEFT_CHK;
				end else if (!sts.x_eq_r) begin
					cmd.pos = bgtrim_pkg::POS_STEP_X;
				end else if (!sts.y_eq_b) begin
					cmd.pos = bgtrim_pkg::POS_ROW_DOWN;
				end else begin
					// whole rectangle is background
					cmd.side = bgtrim_pkg::SIDE_FLAG;
					state_d  = S_OUT;
				end
			end
			S_LEFT_CHK: begin
				if (sts.l_lt_r) begin
					cmd.pos = bgtrim_pkg::POS_START_TL;
					state_d = S_LEFT_SCAN;
				end else begin
					state_d = S_BOT_CHK;
				end
			end
			S_LEFT_SCAN: begin
				if (!sts.match) begin
					state_d = S_BOT_CHK;
				end else if (!sts.y_eq_b) begin
					cmd.pos = bgtrim_pkg::POS_STEP_Y;
				end else begin
					cmd.side = bgtrim_pkg::SIDE_L_INC;
					if (sts.xp1_eq_r) begin
						state_d = S_BOT_CHK;
					end else begin
						cmd.pos = bgtrim_pkg::POS_COL_RIGHT;
					end
				end
			end
			S_BOT_CHK: begin
				if (sts.t_lt_b) begin
					cmd.pos = bgtrim_pkg::POS_START_BL;
					state_d = S_BOT_SCAN;
				end else begin
					state_d = S_RIGHT_CHK;
				end
			end
			S_BOT_SCAN: begin
				if (!sts.match) begin
					state_d = S_RIGHT_CHK;
				end else if (!sts.x_eq_r) begin
					cmd.pos = bgtrim_pkg::POS_STEP_X;
				end else begin
					cmd.side = bgtrim_pkg::SIDE_B_DEC;
					if (sts.ym1_eq_t) begin
						state_d = S_RIGHT_CHK;
					end else begin
						cmd.pos = bgtrim_pkg::POS_ROW_UP;
					end
				end
			end
			S_RIGHT_CHK: begin
				if (sts.l_lt_r) begin
					cmd.pos = bgtrim_pkg::POS_START_TR;
					state_d = S_RIGHT_SCAN;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RIGHT_SCAN: begin
				if (!sts.match) begin
					state_d = S_OUT;
				end else if (!sts.y_eq_b) begin
					cmd.pos = bgtrim_pkg::POS_STEP_Y;
				end else begin
					cmd.side = bgtrim_pkg::SIDE_R_DEC;
					if (sts.xm1_eq_l) begin
						state_d = S_OUT;
					end else begin
						cmd.pos = bgtrim_pkg::POS_COL_LEFT;
					end
				end
			end
			S_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd == bgtrim_pkg::CMD_QUERY |=> state_q == S_TOP_CHK)
		else $error("query beat did not start a trim");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd == bgtrim_pkg::CMD_WRITE |=> state_q == S_IDLE)
		else $error("pixel write left idle");

	a_out_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && !sts.out_full |=> state_q == S_IDLE)
		else $error("result not handed off");

	a_right_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RIGHT_SCAN && !sts.match |=> state_q == S_OUT)
		else $error("right scan did not finish on content");

endmodule

[hdl/bgtrim_dp.sv]
// Datapath for the background trim block: size registers, pixel store,
// scan position, rectangle sides and result register. Uses bgtrim_pkg.
module bgtrim_dp #(
	parameter int MAX_WIDTH  = bgtrim_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgtrim_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bgtrim_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgtrim_pkg::CFG_W-1:0]     cfg_data,
	input  bgtrim_pkg::req_t                 req_data,
	input  bgtrim_pkg::ctl_cmd_t             cmd,
	output bgtrim_pkg::dp_sts_t              sts,
	bgtrim_chan_if.source                    rsp
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CW    = (XW > YW) ? XW : YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [bgtrim_pkg::CFG_W-1:0] width_q;
	logic [bgtrim_pkg::CFG_W-1:0] height_q;

	logic [XW-1:0] hi_x;
	logic [YW-1:0] hi_y;

	logic [31:0]   pix_mem_q [DEPTH];
	logic [31:0]   rd_q;
	logic [31:0]   avoid_q;
	logic [XW-1:0] cx_q, l_q, r_q, nx;
	logic [YW-1:0] cy_q, t_q, b_q, ny;
	logic          flag_q;
	logic          wr_ok;
	logic [XW-1:0] ax;
	logic [YW-1:0] ay;
	logic [AW-1:0] addr;

	// clamp a signed coordinate into 0..hi
	function automatic logic [CW-1:0] clamp_c(logic signed [15:0] v, logic [CW-1:0] hi);
		logic signed [16:0] hs;
		hs = $signed({1'b0, 16'(hi)});
		if (v < 0) begin
			return '0;
		end else if (17'(v) > hs) begin
			return hi;
		end else begin
			return CW'(unsigned'(v));
		end
	endfunction

	function automatic logic in_range(logic signed [15:0] v, logic [CW-1:0] hi);
		logic signed [16:0] hs;
		hs = $signed({1'b0, 16'(hi)});
		return (v >= 0) && (17'(v) <= hs);
	endfunction

	// size zero acts as one, sizes above the maximum saturate
	always_comb begin
		if (width_q == '0) begin
			hi_x = '0;
		end else if (32'(width_q) >= MAX_WIDTH) begin
			hi_x = XW'(MAX_WIDTH - 1);
		end else begin
			hi_x = XW'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			hi_y = '0;
		end else if (32'(height_q) >= MAX_HEIGHT) begin
			hi_y = YW'(MAX_HEIGHT - 1);
		end else begin
			hi_y = YW'(height_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bgtrim_pkg::CFG_SIZE_RESET;
			height_q <= bgtrim_pkg::CFG_SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bgtrim_pkg::CFG_IDX_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == bgtrim_pkg::CFG_IDX_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	always_comb begin
		nx = cx_q;
		ny = cy_q;
		case (cmd.pos)
			bgtrim_pkg::POS_HOLD: begin
			end
			bgtrim_pkg::POS_START_TL: begin
				nx = l_q;
				ny = t_q;
			end
			bgtrim_pkg::POS_START_BL: begin
				nx = l_q;
				ny = b_q;
			end
			bgtrim_pkg::POS_START_TR: begin
				nx = r_q;
				ny = t_q;
			end
			bgtrim_pkg::POS_STEP_X: begin
				nx = cx_q + 1'b1;
			end
			bgtrim_pkg::POS_STEP_Y: begin
				ny = cy_q + 1'b1;
			end
			bgtrim_pkg::POS_ROW_DOWN: begin
				nx = l_q;
				ny = cy_q + 1'b1;
			end
			bgtrim_pkg::POS_ROW_UP: begin
				nx = l_q;
				ny = cy_q - 1'b1;
			end
			bgtrim_pkg::POS_COL_RIGHT: begin
				nx = cx_q + 1'b1;
				ny = t_q;
			end
			bgtrim_pkg::POS_COL_LEFT: begin
				nx = cx_q - 1'b1;
				ny = t_q;
			end
			default: begin
			end
		endcase
	end

	// one address port shared by pixel writes (idle) and scan reads
	assign wr_ok = in_range(req_data.pix_x, CW'(hi_x)) && in_range(req_data.pix_y, CW'(hi_y));
	assign ax    = cmd.wr_en ? XW'(unsigned'(req_data.pix_x)) : nx;
	assign ay    = cmd.wr_en ? YW'(unsigned'(req_data.pix_y)) : ny;
	assign addr  = AW'(ay) * AW'(MAX_WIDTH) + AW'(ax);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			pix_mem_q[addr] <= req_data.pixel_value;
		end
		rd_q <= pix_mem_q[addr];
	end

	always_ff @(posedge clk) begin
		cx_q <= nx;
		cy_q <= ny;
		if (cmd.load) begin
			l_q     <= XW'(clamp_c(req_data.rect_left, CW'(hi_x)));
			t_q     <= YW'(clamp_c(req_data.rect_top, CW'(hi_y)));
			r_q     <= XW'(clamp_c(req_data.rect_right, CW'(hi_x)));
			b_q     <= YW'(clamp_c(req_data.rect_bottom, CW'(hi_y)));
			avoid_q <= req_data.avoid_color;
			flag_q  <= 1'b0;
		end else begin
			case (cmd.side)
				bgtrim_pkg::SIDE_NONE: begin
				end
				bgtrim_pkg::SIDE_T_SET: begin
					t_q <= cy_q;
				end
				bgtrim_pkg::SIDE_L_INC: begin
					l_q <= l_q + 1'b1;
				end
				bgtrim_pkg::SIDE_B_DEC: begin
					b_q <= b_q - 1'b1;
				end
				bgtrim_pkg::SIDE_R_DEC: begin
					r_q <= r_q - 1'b1;
				end
				bgtrim_pkg::SIDE_FLAG: begin
					flag_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.inverted = (l_q > r_q) || (t_q > b_q);
	assign sts.match    = (rd_q == avoid_q);
	assign sts.x_eq_r   = (cx_q == r_q);
	assign sts.y_eq_b   = (cy_q == b_q);
	assign sts.xp1_eq_r = (({1'b0, cx_q} + 1'b1) == {1'b0, r_q});
	assign sts.ym1_eq_t = (({1'b0, t_q} + 1'b1) == {1'b0, cy_q});
	assign sts.xm1_eq_l = (({1'b0, l_q} + 1'b1) == {1'b0, cx_q});
	assign sts.l_lt_r   = (l_q < r_q);
	assign sts.t_lt_b   = (t_q < b_q);
	assign sts.out_full = rsp.valid && !rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (cmd.out_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.data.out_left       <= 8'(l_q);
			rsp.data.out_top        <= 8'(t_q);
			rsp.data.out_right      <= 8'(r_q);
			rsp.data.out_bottom     <= 8'(b_q);
			rsp.data.all_background <= flag_q;
		end
	end

endmodule

[hdl/background_trim_bounding_box.sv]
// Top level of the background trim bounding box block.
// Joins bgtrim_ctrl and bgtrim_dp; uses bgtrim_pkg and bgtrim_chan_if.
//
// The block holds a MAX_WIDTH x MAX_HEIGHT image of packed RGBA pixels, pixel
// (x,y) at address y*MAX_WIDTH+x, in a single-port store with a registered
// read. A write beat (cmd 0) stores one pixel; pixels outside the image set
// by the size registers are dropped, and while the block is idle writes
// stream at one beat per cycle. A query beat (cmd 1) clips its rectangle to
// the image, then trims the top, left, bottom and right sides in that order
// past rows and columns that hold only the avoid color, and returns one
// result beat. After a query is taken the controller runs a clip check, one
// pixel read per scan step, a check before each of the left, bottom and
// right phases (spent even when the phase has nothing to do) and an output
// step. An inverted rectangle skips the scan; an all-background one stops
// after the top scan. While a query runs, req.ready is low; the result sits
// in an output register, so the next beat is taken while a result waits, but
// a query that finishes while the earlier result is still held waits in its
// output state until that result is taken. An all-background or inverted
// rectangle returns the clipped rectangle with all_background set. The store
// has no reset and no clearing pass: query only pixels that were written.
// Size registers must be written only while the block is idle; the block
// itself does not enforce it.
module background_trim_bounding_box #(
	parameter int MAX_WIDTH  = bgtrim_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgtrim_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bgtrim_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgtrim_pkg::CFG_W-1:0]     cfg_data,
	bgtrim_chan_if.sink                      req,
	bgtrim_chan_if.source                    rsp
);

	bgtrim_pkg::ctl_cmd_t cmd;
	bgtrim_pkg::dp_sts_t  sts;
	logic                 ctrl_ready;

	// controller owns the request handshake; datapath sees the payload
	assign req.ready = ctrl_ready;

	bgtrim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.data.cmd),
		.req_ready (ctrl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bgtrim_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
